// ===== rtl/planar_vector_angle_assert.svh =====
// Assertion macros shared by the planar vector angle RTL.
// Included by modules that carry concurrent checks; no other dependency.
`ifndef PLANAR_VECTOR_ANGLE_ASSERT_SVH
`define PLANAR_VECTOR_ANGLE_ASSERT_SVH

// Implication check, disabled during reset.
`define PVA_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication check, disabled during reset.
`define PVA_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== rtl/pva_pkg.sv =====
// Package for the planar vector angle block: angle constants, flags, atan table.
// No dependencies.
package pva_pkg;

    localparam int ROT_STEPS = 32;
    localparam logic [35:0] PI_Q32      = 36'h3243F6A89;
    localparam logic [35:0] HALF_PI_Q32 = 36'h1921FB544;
    localparam logic [35:0] TWO_PI_Q32  = 36'h6487ED511;
    localparam logic [15:0] RATIO_RESET = 16'd655;

    // shift-subtract quotient, used only while building the table
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q32
    function automatic logic [35:0] atan_q32(input int i);
        longint unsigned acc;
        longint unsigned term;
        int e;
        if (i == 0) begin
            return 36'((64'h3243F6A8885A308D + 64'd536870912) >> 30);
        end
        acc = 64'd0;
        for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
                term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
                if (k[0]) acc = acc - term;
                else acc = acc + term;
            end
        end
        return 36'((acc + 64'd536870912) >> 30);
    endfunction

    // status carried with each item along the pipe
    typedef struct packed {
        logic dneg;
        logic cneg;
        logic dzero;
        logic coll;
        logic degen;
    } t_flags;

endpackage

// ===== rtl/pva_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on nothing but its parameters.
module pva_isqrt #(
    parameter int IN_W = 34,
    parameter int OUT_W = 17
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [IN_W-1:0]  i_val,
    output logic [OUT_W-1:0] o_root
);
    localparam int RW = 2 * OUT_W;

    logic [RW-1:0]    r_rem [OUT_W+1];
    logic [OUT_W-1:0] r_rt  [OUT_W+1];

    assign r_rem[0] = RW'(i_val);
    assign r_rt[0]  = '0;

    // stage s decides root bit OUT_W-1-s
    for (genvar s = 0; s < OUT_W; s++) begin : g_st
        localparam int B = OUT_W - 1 - s;
        logic [RW-1:0] trial;
        logic [RW-1:0] n_rem;
        logic [OUT_W-1:0] n_rt;
        logic [RW-1:0] r_q;
        logic [OUT_W-1:0] r_r;
        always_comb begin
            trial = (RW'(r_rt[s]) << (B + 1)) + (RW'(1) << (2 * B));
            if (r_rem[s] >= trial) begin
                n_rem = r_rem[s] - trial;
                n_rt  = r_rt[s] | (OUT_W'(1) << B);
            end else begin
                n_rem = r_rem[s];
                n_rt  = r_rt[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q <= n_rem;
                r_r <= n_rt;
            end
        end
        assign r_rem[s+1] = r_q;
        assign r_rt[s+1]  = r_r;
    end

    assign o_root = r_rt[OUT_W];
endmodule

// ===== rtl/pva_cordic.sv =====
// Pipelined vectoring rotations producing atan2(y, x) in Q32.
// Depends on pva_pkg for the atan table.
module pva_cordic (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_x,
    input  logic [63:0] i_y,
    output logic [35:0] o_z
);
    import pva_pkg::*;

    logic signed [63:0] w_x [ROT_STEPS+1];
    logic signed [63:0] w_y [ROT_STEPS+1];
    logic signed [37:0] w_z [ROT_STEPS+1];

    assign w_x[0] = signed'(i_x);
    assign w_y[0] = signed'(i_y);
    assign w_z[0] = '0;

    // one rotation per stage
    for (genvar i = 0; i < ROT_STEPS; i++) begin : g_rot
        localparam logic [37:0] ANG = 38'(atan_q32(i));
        logic signed [63:0] r_x, r_y;
        logic signed [37:0] r_z;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_y[i][63]) begin
                    r_x <= w_x[i] + (w_y[i] >>> i);
                    r_y <= w_y[i] - (w_x[i] >>> i);
                    r_z <= w_z[i] + signed'(ANG);
                end else begin
                    r_x <= w_x[i] - (w_y[i] >>> i);
                    r_y <= w_y[i] + (w_x[i] >>> i);
                    r_z <= w_z[i] - signed'(ANG);
                end
            end
        end
        assign w_x[i+1] = r_x;
        assign w_y[i+1] = r_y;
        assign w_z[i+1] = r_z;
    end

    // clamp to [0, pi/2]
    always_comb begin
        if (w_z[ROT_STEPS][37]) o_z = '0;
        else if (w_z[ROT_STEPS] > signed'({2'b00, HALF_PI_Q32})) o_z = HALF_PI_Q32;
        else o_z = w_z[ROT_STEPS][35:0];
    end
endmodule

// ===== rtl/planar_vector_angle.sv =====
// Planar vector angle: counter-clockwise angle from vector a to vector b.
//
// Use: an input request carries a_x, a_y, b_x, b_y on i_in_valid/o_in_stall;
// a result request carries angle_rad, collinear, degenerate on
// o_out_valid/i_out_stall. The collinear_ratio register is written on its
// own channel (i_cfg_valid/o_cfg_ready); the user must write it only while
// the block is idle, which the block itself does not enforce. Throughput:
// one item per cycle while the output is not held. The pipe holds a product
// and a sum stage, COORD_WIDTH+1 square root stages, a threshold and a
// normalize stage, 32 rotation stages and the output register. Every stage
// advances together when the output is not held; a held output stalls the
// whole pipe, so o_in_stall follows a full, stalled output stage.
// Reset (synchronous, active low) clears all valid bits and loads the
// ratio register with 655 (0.01 in Q0.16).
// Zero-length vectors give degenerate=1 and angle 0.
module planar_vector_angle #(
    parameter int COORD_WIDTH = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [COORD_WIDTH-1:0] i_a_x,
    input  logic [COORD_WIDTH-1:0] i_a_y,
    input  logic [COORD_WIDTH-1:0] i_b_x,
    input  logic [COORD_WIDTH-1:0] i_b_y,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [15:0]            i_cfg_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [15:0]            o_angle_rad,
    output logic                   o_collinear,
    output logic                   o_degenerate
);
    import pva_pkg::*;
    `include "planar_vector_angle_assert.svh"

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = 2 * CW;       // product width
    localparam int SW  = 2 * CW + 1;   // sum width
    localparam int RTW = CW + 1;       // root width
    localparam int DEPTH = 2 + RTW + 2 + ROT_STEPS + 1;

    logic [15:0] r_ratio;
    logic        w_en;
    logic [DEPTH-1:0] r_vld;

    assign w_en = !(r_vld[DEPTH-1] && i_out_stall);
    assign o_in_stall = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_RESET;
        end else if (i_cfg_valid) begin
            r_ratio <= i_cfg_data;
        end
    end

    // valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in_valid};
        end
    end

    // stage 1: products
    logic signed [PW-1:0] r_axbx, r_ayby, r_axby, r_bxay, r_axax, r_ayay, r_bxbx, r_byby;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_axbx <= PW'(signed'(i_a_x)) * PW'(signed'(i_b_x));
            r_ayby <= PW'(signed'(i_a_y)) * PW'(signed'(i_b_y));
            r_axby <= PW'(signed'(i_a_x)) * PW'(signed'(i_b_y));
            r_bxay <= PW'(signed'(i_b_x)) * PW'(signed'(i_a_y));
            r_axax <= PW'(signed'(i_a_x)) * PW'(signed'(i_a_x));
            r_ayay <= PW'(signed'(i_a_y)) * PW'(signed'(i_a_y));
            r_bxbx <= PW'(signed'(i_b_x)) * PW'(signed'(i_b_x));
            r_byby <= PW'(signed'(i_b_y)) * PW'(signed'(i_b_y));
        end
    end

    // stage 2: sums, signs and magnitudes
    logic signed [SW:0] w_dot, w_crs;
    logic [SW-1:0] r_sa, r_sb, r_dotm, r_crm;
    t_flags r_f2;
    assign w_dot = (SW+1)'(r_axbx) + (SW+1)'(r_ayby);
    assign w_crs = (SW+1)'(r_axby) - (SW+1)'(r_bxay);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sa <= SW'($unsigned(r_axax)) + SW'($unsigned(r_ayay));
            r_sb <= SW'($unsigned(r_bxbx)) + SW'($unsigned(r_byby));
            r_dotm <= w_dot[SW] ? SW'(-w_dot) : SW'(w_dot);
            r_crm  <= w_crs[SW] ? SW'(-w_crs) : SW'(w_crs);
            r_f2.dneg  <= w_dot[SW];
            r_f2.cneg  <= w_crs[SW];
            r_f2.dzero <= (w_dot == '0);
            r_f2.coll  <= 1'b0;
            r_f2.degen <= 1'b0;
        end
    end

    // square roots, with dot/cross delayed alongside
    logic [RTW-1:0] w_la, w_lb;
    pva_isqrt #(.IN_W(SW), .OUT_W(RTW)) u_sqa (
        .i_clk(i_clk), .i_en(w_en), .i_val(r_sa), .o_root(w_la));
    pva_isqrt #(.IN_W(SW), .OUT_W(RTW)) u_sqb (
        .i_clk(i_clk), .i_en(w_en), .i_val(r_sb), .o_root(w_lb));

    // zero-length check joins the flags
    t_flags w_f2d;
    always_comb begin
        w_f2d = r_f2;
        w_f2d.degen = (r_sa == '0) || (r_sb == '0);
    end

    logic [SW-1:0] r_dd [RTW];
    logic [SW-1:0] r_cd [RTW];
    t_flags        r_fd [RTW];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dd[0] <= r_dotm;
            r_cd[0] <= r_crm;
            r_fd[0] <= w_f2d;
            for (int k = 1; k < RTW; k++) begin
                r_dd[k] <= r_dd[k-1];
                r_cd[k] <= r_cd[k-1];
                r_fd[k] <= r_fd[k-1];
            end
        end
    end

    // stage: threshold multiply
    logic [RTW+16:0] r_thrp;
    logic [SW-1:0] r_d3, r_c3;
    t_flags r_f3;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_thrp <= (RTW+17)'(r_ratio) * ((RTW+17)'(w_la) + (RTW+17)'(w_lb));
            r_d3 <= r_dd[RTW-1];
            r_c3 <= r_cd[RTW-1];
            r_f3 <= r_fd[RTW-1];
        end
    end

    // stage: compare and normalize to [2^58, 2^59)
    logic [63:0] w_ux, w_uy;
    logic [SW-1:0] w_mx;
    int w_lz;
    t_flags w_f4;
    always_comb begin
        w_mx = (r_d3 > r_c3) ? r_d3 : r_c3;
        w_lz = 0;
        for (int k = 0; k < SW; k++) begin
            if (w_mx[k]) w_lz = k;
        end
        if (w_lz > 58) begin
            w_ux = 64'(r_d3 >> (w_lz - 58));
            w_uy = 64'(r_c3 >> (w_lz - 58));
        end else begin
            w_ux = 64'(r_d3) << (58 - w_lz);
            w_uy = 64'(r_c3) << (58 - w_lz);
        end
        w_f4 = r_f3;
        w_f4.coll = (64'(r_c3) <= 64'(r_thrp >> 16));
    end
    logic [63:0] r_ux, r_uy;
    t_flags r_f4;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ux <= w_ux;
            r_uy <= w_uy;
            r_f4 <= w_f4;
        end
    end

    logic [35:0] w_z;
    pva_cordic u_cordic (.i_clk(i_clk), .i_en(w_en), .i_x(r_ux), .i_y(r_uy), .o_z(w_z));

    t_flags r_fc [ROT_STEPS];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fc[0] <= r_f4;
            for (int k = 1; k < ROT_STEPS; k++) r_fc[k] <= r_fc[k-1];
        end
    end

    // final: quadrant fixup, rounding, saturation
    logic [35:0] w_ang;
    logic [36:0] w_rnd;
    logic [15:0] w_out;
    t_flags w_ff;
    always_comb begin
        w_ff = r_fc[ROT_STEPS-1];
        w_ang = w_ff.dneg ? PI_Q32 - w_z : w_z;
        if (!w_ff.coll) begin
            if (w_ff.cneg) w_ang = TWO_PI_Q32 - w_ang;
        end else if (!w_ff.dneg && !w_ff.dzero) begin
            w_ang = TWO_PI_Q32;
        end
        w_rnd = (37'(w_ang) + (37'(1) << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS);
        w_out = (w_rnd > 37'd65535) ? 16'hFFFF : w_rnd[15:0];
    end

    logic [15:0] r_ang;
    logic r_col, r_deg;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ang <= w_ff.degen ? 16'd0 : w_out;
            r_col <= w_ff.degen ? 1'b0 : w_ff.coll;
            r_deg <= w_ff.degen;
        end
    end

    assign o_out_valid  = r_vld[DEPTH-1];
    assign o_angle_rad  = r_ang;
    assign o_collinear  = r_col;
    assign o_degenerate = r_deg;

    `PVA_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_angle_rad))
    `PVA_ASSERT_IMP(a_deg_zero, i_clk, i_rst_n, o_out_valid && o_degenerate, o_angle_rad == 16'd0 && !o_collinear)
    `PVA_ASSERT_IMP(a_stall_src, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
endmodule

// ===== tb/tb.sv =====
// Testbench for planar_vector_angle: random and directed vector pairs, with a
// scoreboard class that predicts angle, collinear and degenerate flags.
// Depends on rtl/pva_pkg.sv (angle constants, reset ratio) and the RTL top.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] angle;
        logic        coll;
        logic        degen;
    } t_angle_res;

    // Scoreboard: predicts each pair's angle and holds the results in flight
    class t_angle_board;
        t_angle_res pending[$];
        logic [15:0] ratio;
        longint atan_tab[32];
        string msg;

        function new();
            longint acc;
            longint term;
            int e;
            ratio = pva_pkg::RATIO_RESET;
            atan_tab[0] = (64'h3243F6A8885A308D + (64'd1 << 29)) >> 30;
            for (int i = 1; i < 32; i++) begin
                acc = 0;
                for (int k = 0; k < 32; k++) begin
                    e = i * (2 * k + 1);
                    if (e <= 62) begin
                        term = (64'sd1 << (62 - e)) / longint'(2 * k + 1);
                        acc = (k % 2 == 1) ? acc - term : acc + term;
                    end
                end
                atan_tab[i] = (acc + (64'sd1 << 29)) >>> 30;
            end
        endfunction

        function longint int_root(longint v);
            longint r;
            longint b;
            r = 0;
            b = 64'sd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // accepted input request: work out its result
        function void note(logic signed [15:0] ax, logic signed [15:0] ay,
                           logic signed [15:0] bx, logic signed [15:0] by);
            longint sa, sq_b, dot, crs, dm, cm, thr, ux, uy, mx, x, y, z, xs, ys, ang;
            bit dn, cn, coll;
            t_angle_res r;
            sa = longint'(ax) * ax + longint'(ay) * ay;
            sq_b = longint'(bx) * bx + longint'(by) * by;
            if (sa == 0 || sq_b == 0) begin
                r.angle = 0;
                r.coll = 0;
                r.degen = 1;
                pending.push_back(r);
                return;
            end
            dot = longint'(ax) * bx + longint'(ay) * by;
            crs = longint'(ax) * by - longint'(bx) * ay;
            dn = dot < 0;
            cn = crs < 0;
            dm = dn ? -dot : dot;
            cm = cn ? -crs : crs;
            thr = (longint'(ratio) * (int_root(sa) + int_root(sq_b))) >> 16;
            coll = cm <= thr;
            // scale so the larger part lies in [2^58, 2^59)
            ux = dm;
            uy = cm;
            mx = (ux > uy) ? ux : uy;
            while (mx >= (64'sd1 << 59)) begin
                ux = ux >> 1; uy = uy >> 1; mx = mx >> 1;
            end
            while (mx < (64'sd1 << 58)) begin
                ux = ux << 1; uy = uy << 1; mx = mx << 1;
            end
            x = ux;
            y = uy;
            z = 0;
            for (int i = 0; i < 32; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys; y = y - xs; z = z + atan_tab[i];
                end else begin
                    x = x - ys; y = y + xs; z = z - atan_tab[i];
                end
            end
            if (z < 0) z = 0;
            if (z > longint'(pva_pkg::HALF_PI_Q32)) z = longint'(pva_pkg::HALF_PI_Q32);
            ang = dn ? longint'(pva_pkg::PI_Q32) - z : z;
            if (!coll) begin
                if (cn) ang = longint'(pva_pkg::TWO_PI_Q32) - ang;
            end else if (!dn && dm != 0) begin
                ang = longint'(pva_pkg::TWO_PI_Q32);
            end
            ang = (ang + (64'sd1 << 18)) >>> 19;
            r.angle = (ang > 65535) ? 16'hFFFF : ang[15:0];
            r.coll = coll;
            r.degen = 0;
            pending.push_back(r);
        endfunction

        // accepted result request: compare with the oldest expectation
        function bit check(logic [15:0] angle, logic coll, logic degen);
            t_angle_res e;
            if (pending.size() == 0) begin
                msg = $sformatf("unexpected result angle=%0d coll=%0b degen=%0b",
                                angle, coll, degen);
                return 0;
            end
            e = pending.pop_front();
            if (angle !== e.angle || coll !== e.coll || degen !== e.degen) begin
                msg = $sformatf("got angle=%0d coll=%0b degen=%0b, want %0d %0b %0b",
                                angle, coll, degen, e.angle, e.coll, e.degen);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [15:0] i_a_x = 0, i_a_y = 0, i_b_x = 0, i_b_y = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [15:0] o_angle_rad;
    logic        o_collinear;
    logic        o_degenerate;

    t_angle_board board = new();
    int  fail_count = 0;
    bit  idle_on = 0;

    planar_vector_angle uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_b_x(i_b_x), .i_b_y(i_b_y),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_angle_rad(o_angle_rad), .o_collinear(o_collinear), .o_degenerate(o_degenerate)
    );

    always #5 i_clk = ~i_clk;

    task automatic report(string s);
        fail_count++;
        $display("MISMATCH @%0t: %s", $time, s);
    endtask

    // watch both channels
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            board.note(i_a_x, i_a_y, i_b_x, i_b_y);
        if (i_rst_n && o_out_valid && !i_out_stall)
            if (!board.check(o_angle_rad, o_collinear, o_degenerate)) report(board.msg);
    end

    // result side back-pressure
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = idle_on ? $urandom_range(0, 17) : 0;
            if (n > 0) begin
                i_out_stall <= 1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 0;
            end
            @(posedge i_clk iff o_out_valid);
        end
    end

    task automatic send_pair(logic [15:0] ax, logic [15:0] ay, logic [15:0] bx, logic [15:0] by);
        int gap;
        gap = idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_a_x <= ax; i_a_y <= ay; i_b_x <= bx; i_b_y <= by;
        @(posedge i_clk iff !o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_ratio(logic [15:0] v);
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        @(posedge i_clk iff o_cfg_ready);
        i_cfg_valid <= 0;
        board.ratio = v;
    endtask

    function automatic logic [15:0] coord(int kind);
        case (kind)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 16) - 8);
            default: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        endcase
    endfunction

    // random pairs: free, small, near-collinear and with zero vectors
    task automatic random_phase(int count);
        logic signed [15:0] ax, ay, bx, by;
        int kind;
        int k;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            ax = coord(kind < 4 ? 0 : kind < 7 ? 1 : 0);
            ay = coord(kind < 4 ? 0 : kind < 7 ? 1 : 0);
            bx = coord(kind < 4 ? 0 : kind < 7 ? 1 : 0);
            by = coord(kind < 4 ? 0 : kind < 7 ? 1 : 0);
            if (kind == 7 || kind == 8) begin
                // b is a multiple of a, plus a little noise
                ax = 16'($signed(ax) >>> $urandom_range(0, 12));
                ay = 16'($signed(ay) >>> $urandom_range(0, 12));
                k = $urandom_range(0, 6) - 3;
                bx = 16'(ax * k + $urandom_range(0, 4) - 2);
                by = 16'(ay * k + $urandom_range(0, 4) - 2);
            end else if (kind == 9) begin
                if ($urandom_range(0, 1)) begin
                    ax = 0; ay = 0;
                end else begin
                    bx = 0; by = 0;
                end
            end
            if ($urandom_range(0, 15) == 0) ax = coord(2);
            send_pair(ax, ay, bx, by);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: zero vectors, extremes, axes, collinear cases
        send_pair(0, 0, 1, 1);
        send_pair(5, 5, 0, 0);
        send_pair(0, 0, 0, 0);
        send_pair(16'sd32767, 0, 16'sd32767, 0);
        send_pair(1, 0, -16'sd1, 0);
        send_pair(1, 0, 0, 1);
        send_pair(1, 0, 0, -16'sd1);
        send_pair(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768);
        send_pair(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
        send_pair(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
        send_pair(-16'sd1, -16'sd1, 1, -16'sd1);
        send_pair(3, 4, -16'sd4, 3);
        send_pair(100, 1, 100, 0);
        send_pair(100, 0, 100, 1);
        send_pair(0, -16'sd32768, 0, 16'sd32767);
        send_pair(-16'sd32768, 0, -16'sd32768, 0);
        send_pair(1, 1, -16'sd1, 0);
        drain();

        idle_on = 1;
        random_phase(450);
        drain();
        write_ratio(16'd0);
        random_phase(400);
        drain();
        write_ratio(16'hFFFF);
        idle_on = 0;
        random_phase(300);
        drain();
        write_ratio(16'($urandom));
        idle_on = 1;
        random_phase(400);
        drain();
        write_ratio(pva_pkg::RATIO_RESET);
        random_phase(400);
        drain();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
